// File: hw/rtl/vffns_pkg.sv
`timescale 1ns / 1ps

package vffns_pkg;

    // Angles are signed Q3.13 radians
    localparam int PI_Q13       = 25736;
    localparam int HALF_PI_Q13  = 12868;
    localparam int TWO_PI_Q13   = 51472;
    // Reciprocal of the CORDIC gain, Q0.15
    localparam int INV_GAIN_Q15 = 19898;

    typedef enum logic [2:0] {
        REG_ATTRACT_GAIN  = 3'd0,
        REG_REPEL_GAIN    = 3'd1,
        REG_LINEAR_LIMIT  = 3'd2,
        REG_ANGULAR_LIMIT = 3'd3,
        REG_DETECT_LIMIT  = 3'd4,
        REG_RANGE_FLOOR   = 3'd5,
        REG_START_ANGLE   = 3'd6,
        REG_ANGLE_STEP    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_ctl;

    // Arctangent of 2^-i in Q3.13, rounded; zero from index 14 on
    function automatic logic [12:0] atan_q13(input logic [4:0] idx);
        logic [12:0] v;
        case (idx)
            5'd0:    v = 13'd6434;
            5'd1:    v = 13'd3798;
            5'd2:    v = 13'd2007;
            5'd3:    v = 13'd1019;
            5'd4:    v = 13'd511;
            5'd5:    v = 13'd256;
            5'd6:    v = 13'd128;
            5'd7:    v = 13'd64;
            5'd8:    v = 13'd32;
            5'd9:    v = 13'd16;
            5'd10:   v = 13'd8;
            5'd11:   v = 13'd4;
            5'd12:   v = 13'd2;
            5'd13:   v = 13'd1;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/vff_nearest_obstacle_steer.sv
`timescale 1ns / 1ps

// Nearest-obstacle steering from one laser scan. Range samples come in scan
// order, one word per cycle while the input is ready: for each, the block
// tracks the beam angle and the nearest sample inside [range_floor,
// detect_limit] (earliest wins a tie). The word flagged last_sample closes the
// scan and produces one result word; while it is worked on, the input is not
// ready. Closing a scan runs the restoring divider (skipped when nothing was
// seen or the range is zero), two passes through the shared CORDIC unit
// (only the vectoring pass when no sample was seen), and up to six steps for
// loading, the shared constant multiplier and clipping; the result then
// waits in the output register until taken. Configuration writes take
// effect at once, except start_angle, which is loaded into the beam angle as
// each scan closes.
module vff_nearest_obstacle_steer #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_range_sample,
    input  logic               i_last_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_lin_vel,
    output logic signed [15:0] o_ang_vel,
    output logic               o_obstacle_seen,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    localparam int F     = FRAC_BITS;
    localparam int W     = F + 11;       // vector component width
    localparam int ZW    = 18;           // CORDIC angle accumulator
    localparam int QW    = F + 8;        // saturated repulsion size
    localparam int NUM_W = 16 + F;       // divider dividend
    localparam int PW    = W + 15;       // shared multiplier product

    localparam logic signed [W-1:0]   SAT    = $signed({3'b000, {(F+8){1'b1}}});
    localparam logic signed [W+1:0]   SAT_X  = {2'b00, SAT};
    localparam logic [NUM_W-1:0]      SAT_Q  = {8'd0, {(F+8){1'b1}}};
    localparam logic [14:0]           INV    = 15'(vffns_pkg::INV_GAIN_Q15);
    localparam logic signed [16:0]    PI17   = 17'(vffns_pkg::PI_Q13);
    localparam logic signed [16:0]    TWO17  = 17'(vffns_pkg::TWO_PI_Q13);
    localparam logic signed [ZW-1:0]  PI_Z   = ZW'(vffns_pkg::PI_Q13);
    localparam logic signed [ZW-1:0]  HPI_Z  = ZW'(vffns_pkg::HALF_PI_Q13);

    typedef enum logic [3:0] {
        S_SCAN, S_DIV_LD, S_DIV, S_SCALE, S_ROT_LD, S_ROT,
        S_SUM, S_VEC, S_MAG, S_FIN, S_OUT
    } t_state;

    function automatic logic signed [15:0] wrap_angle(input logic signed [16:0] a);
        logic signed [16:0] v;
        v = a;
        if (a > PI17) begin
            v = a - TWO17;
        end else if (a < -PI17) begin
            v = a + TWO17;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
        logic signed [W-1:0] r;
        r = v[W-1:0];
        if (v > SAT_X) begin
            r = SAT;
        end else if (v < -SAT_X) begin
            r = -SAT;
        end
        return r;
    endfunction

    // Configuration registers
    logic [15:0]        r_attract_gain, r_repel_gain, r_linear_limit;
    logic [14:0]        r_angular_limit;
    logic [15:0]        r_detect_limit, r_range_floor;
    logic signed [15:0] r_start_angle;
    logic signed [13:0] r_angle_step;

    // Scan state
    logic [15:0]        r_near_range;
    logic signed [15:0] r_near_angle;
    logic signed [15:0] r_beam_angle;
    logic               r_found;

    // Closing sequence
    t_state              r_state;
    logic                r_seen;
    logic [15:0]         r_cr;
    logic signed [15:0]  r_ca;
    logic [QW-1:0]       r_m;
    logic [PW-1:0]       r_prod;
    logic signed [W-1:0] r_rx, r_ry;
    logic [W-1:0]        r_vx;
    logic signed [ZW-1:0] r_vz;
    logic [15:0]         r_lin;
    logic signed [15:0]  r_ang;

    // Per-word tracking
    logic               accept;
    logic               in_win, take;
    logic [15:0]        n_near_range;
    logic signed [15:0] n_near_angle;
    logic               n_found;
    logic signed [15:0] n_beam_angle;

    assign accept = i_valid && o_ready;
    assign in_win = (i_range_sample <= r_detect_limit) && (i_range_sample >= r_range_floor);
    assign take   = in_win && (!r_found || (i_range_sample < r_near_range));

    always_comb begin
        n_near_range = take ? i_range_sample : r_near_range;
        n_near_angle = take ? r_beam_angle : r_near_angle;
        n_found      = r_found || in_win;
        n_beam_angle = wrap_angle({r_beam_angle[15], r_beam_angle}
                                  + {{3{r_angle_step[13]}}, r_angle_step});
    end

    // Shared units
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_quo;
    vffns_pkg::t_cordic_ctl cor_ctl;
    logic              cor_done;
    logic signed [W-1:0]  cor_x0, cor_y0, cor_xo, cor_yo;
    logic signed [ZW-1:0] cor_z0, cor_zo;

    assign div_start = (r_state == S_DIV_LD) && (r_cr != 16'd0);

    vffns_div #(
        .NUM_W (NUM_W),
        .DEN_W (16)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_repel_gain, {F{1'b0}}}),
        .i_den   (r_cr),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Rotation load: repulsion points away from the beam; fold back half-plane
    logic signed [W-1:0]  mc;
    logic signed [ZW-1:0] a_ext;
    logic signed [W+1:0]  att_x;
    logic [NUM_W-1:0]     att_sh;
    logic signed [W-1:0]  sx;

    assign mc     = $signed(r_prod[PW-1:15]);
    assign a_ext  = {{(ZW-16){r_ca[15]}}, r_ca};
    assign att_sh = {r_attract_gain, {F{1'b0}}} >> 12;
    assign att_x  = $signed({9'd0, att_sh[F+3:0]});
    assign sx     = sat_w(att_x + {{2{r_rx[W-1]}}, r_rx});

    always_comb begin
        cor_ctl.start     = (r_state == S_ROT_LD) || (r_state == S_SUM);
        cor_ctl.vectoring = (r_state == S_SUM);
        cor_x0 = -mc;
        cor_y0 = '0;
        cor_z0 = a_ext;
        if (r_state == S_SUM) begin
            cor_x0 = sx;
            cor_y0 = r_ry;
            cor_z0 = '0;
            if (sx < 0) begin
                cor_z0 = (r_ry >= 0) ? PI_Z : -PI_Z;
                cor_x0 = -sx;
                cor_y0 = -r_ry;
            end
        end else if (a_ext > HPI_Z) begin
            cor_z0 = a_ext - PI_Z;
            cor_x0 = mc;
        end else if (a_ext < -HPI_Z) begin
            cor_z0 = a_ext + PI_Z;
            cor_x0 = mc;
        end
    end

    vffns_cordic #(
        .STEPS (CORDIC_STEPS),
        .W     (W),
        .ZW    (ZW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_x     (cor_x0),
        .i_y     (cor_y0),
        .i_z     (cor_z0),
        .o_done  (cor_done),
        .o_x     (cor_xo),
        .o_y     (cor_yo),
        .o_z     (cor_zo)
    );

    // Shared constant multiplier: gain removal for repulsion and magnitude
    logic [W-1:0]    mul_a;
    logic [PW-1:0]   n_prod;
    logic [W-1:0]    mag;
    logic [W+11:0]   lin_w;
    logic signed [ZW-1:0] lim_z;

    assign mul_a  = (r_state == S_SCALE) ? W'(r_m) : r_vx;
    assign n_prod = PW'(mul_a) * PW'(INV);
    assign mag    = r_prod[PW-1:15];
    assign lin_w  = {mag, 12'd0} >> F;
    assign lim_z  = $signed({{(ZW-15){1'b0}}, r_angular_limit});

    assign o_ready         = (r_state == S_SCAN);
    assign o_valid         = (r_state == S_OUT);
    assign o_lin_vel       = r_lin;
    assign o_ang_vel       = r_ang;
    assign o_obstacle_seen = r_seen;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attract_gain  <= 16'd4096;
            r_repel_gain    <= 16'd1434;
            r_linear_limit  <= 16'd463;
            r_angular_limit <= 15'd2294;
            r_detect_limit  <= 16'd1905;
            r_range_floor   <= 16'd0;
            r_start_angle   <= 16'sh9B78;
            r_angle_step    <= 14'sd143;
        end else if (i_cfg_we) begin
            unique case (vffns_pkg::t_reg_idx'(i_cfg_idx))
                vffns_pkg::REG_ATTRACT_GAIN:  r_attract_gain  <= i_cfg_data;
                vffns_pkg::REG_REPEL_GAIN:    r_repel_gain    <= i_cfg_data;
                vffns_pkg::REG_LINEAR_LIMIT:  r_linear_limit  <= i_cfg_data;
                vffns_pkg::REG_ANGULAR_LIMIT: r_angular_limit <= i_cfg_data[14:0];
                vffns_pkg::REG_DETECT_LIMIT:  r_detect_limit  <= i_cfg_data;
                vffns_pkg::REG_RANGE_FLOOR:   r_range_floor   <= i_cfg_data;
                vffns_pkg::REG_START_ANGLE:   r_start_angle   <= i_cfg_data;
                vffns_pkg::REG_ANGLE_STEP:    r_angle_step    <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Sequencer, scan tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SCAN;
            r_near_range <= 16'hFFFF;
            r_near_angle <= '0;
            r_found      <= 1'b0;
            r_beam_angle <= wrap_angle(17'sh1_9B78);
        end else begin
            unique case (r_state)
                S_SCAN: begin
                    if (accept) begin
                        if (i_last_sample) begin
                            // Latch the closing figures and restart the scan
                            r_cr         <= n_near_range;
                            r_ca         <= n_near_angle;
                            r_seen       <= n_found;
                            r_rx         <= '0;
                            r_ry         <= '0;
                            r_near_angle <= n_near_angle;
                            r_near_range <= 16'hFFFF;
                            r_found      <= 1'b0;
                            r_beam_angle <= wrap_angle({r_start_angle[15], r_start_angle});
                            r_state      <= n_found ? S_DIV_LD : S_SUM;
                        end else begin
                            r_near_range <= n_near_range;
                            r_near_angle <= n_near_angle;
                            r_found      <= n_found;
                            r_beam_angle <= n_beam_angle;
                        end
                    end
                end
                S_DIV_LD: begin
                    // Zero range saturates the repulsion outright
                    if (r_cr == 16'd0) begin
                        r_m     <= '1;
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_m     <= (div_quo > SAT_Q) ? {QW{1'b1}} : div_quo[QW-1:0];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_prod  <= n_prod;
                    r_state <= S_ROT_LD;
                end
                S_ROT_LD: r_state <= S_ROT;
                S_ROT: begin
                    if (cor_done) begin
                        r_rx    <= sat_w({{2{cor_xo[W-1]}}, cor_xo});
                        r_ry    <= sat_w({{2{cor_yo[W-1]}}, cor_yo});
                        r_state <= S_SUM;
                    end
                end
                S_SUM: r_state <= S_VEC;
                S_VEC: begin
                    if (cor_done) begin
                        r_vx    <= cor_xo;
                        r_vz    <= cor_zo;
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_prod  <= n_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_lin <= (lin_w > (W+12)'(r_linear_limit)) ? r_linear_limit
                                                               : lin_w[15:0];
                    if (r_vz > lim_z) begin
                        r_ang <= lim_z[15:0];
                    end else if (r_vz < -lim_z) begin
                        r_ang <= 16'(-lim_z);
                    end else begin
                        r_ang <= r_vz[15:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_SCAN;
            endcase
        end
    end

    // Never take a word and offer a result in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while result offered");

    // Divider finishes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside its wait state");

    // Result stays within the configured limits
    a_ang_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ang_vel <= $signed({1'b0, r_angular_limit}))
                  && (o_ang_vel >= -$signed({1'b0, r_angular_limit}))))
        else $error("angular output beyond limit");

    a_lin_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lin_vel <= r_linear_limit))
        else $error("linear output beyond limit");

endmodule

// File: hw/rtl/vffns_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module vffns_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};
    assign o_done  = r_busy && (r_cnt == CW'(NUM_W));
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

endmodule

// File: hw/rtl/vffns_cordic.sv
`timescale 1ns / 1ps

// One CORDIC micro-rotation per cycle, rotation or vectoring mode
module vffns_cordic #(
    parameter int STEPS = 16,
    parameter int W     = 23,
    parameter int ZW    = 18
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vffns_pkg::t_cordic_ctl   i_ctl,
    input  logic signed [W-1:0]      i_x,
    input  logic signed [W-1:0]      i_y,
    input  logic signed [ZW-1:0]     i_z,
    output logic                     o_done,
    output logic signed [W-1:0]      o_x,
    output logic signed [W-1:0]      o_y,
    output logic signed [ZW-1:0]     o_z
);
    localparam int CW = $clog2(STEPS + 1);
    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [W-1:0]  r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_vec;

    logic signed [W-1:0]  dx, dy;
    logic signed [ZW-1:0] at;
    logic                 up, hold;

    assign dx   = r_y >>> r_cnt[IW-1:0];
    assign dy   = r_x >>> r_cnt[IW-1:0];
    assign at   = $signed({{(ZW-13){1'b0}}, vffns_pkg::atan_q13(5'(r_cnt))});
    assign up   = r_vec ? (r_y < 0) : (r_z >= 0);
    assign hold = r_vec && (r_y == 0);

    assign o_done = r_busy && (r_cnt == CW'(STEPS));
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_vec  <= i_ctl.vectoring;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (!hold) begin
                if (up) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
            end
        end
    end

endmodule
